[sv/wdg_pkg.sv]
// Shared types and constants for the multi-channel deadline watchdog.
package wdg_pkg;

    localparam int NUM_SLOTS = 8;
    localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W     = $clog2(NUM_SLOTS + 1);
    localparam int TIME_W    = 32;
    localparam int LINE_W    = 3;
    localparam int MASK_W    = 8;

    typedef enum logic [1:0] {
        KIND_REGISTER = 2'd0,
        KIND_FEED     = 2'd1,
        KIND_CHECK    = 2'd2,
        KIND_CLEAR    = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [TIME_W-1:0] now_ms;
        logic [TIME_W-1:0] limit_ms;
        logic [LINE_W-1:0] line_id;
        t_kind             kind;
    } t_req;

    typedef struct packed {
        logic [MASK_W-1:0] new_breach_mask;
        logic [MASK_W-1:0] overdue_mask;
        logic [LINE_W-1:0] assigned_id;
        logic              ok;
    } t_res;

endpackage

[sv/wdg_ram.sv]
// Simple dual-port RAM: one write port, one registered read port.
module wdg_ram #(
    parameter int DEPTH = 8,
    parameter int WIDTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[sv/wdg_ctrl.sv]
// Request sequencer: slot flags, slot memories and the per-slot check walk.
module wdg_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_ready,
    input  wdg_pkg::t_req i_req,
    output logic          o_res_valid,
    output wdg_pkg::t_res o_res,
    input  logic          i_res_take
);

    localparam int N  = wdg_pkg::NUM_SLOTS;
    localparam int SW = wdg_pkg::SLOT_W;
    localparam int CW = wdg_pkg::CNT_W;
    localparam int TW = wdg_pkg::TIME_W;

    wdg_pkg::t_state r_state, n_state;
    wdg_pkg::t_req   r_req;
    wdg_pkg::t_res   r_res, n_res;
    logic [N-1:0]    r_armed, n_armed;
    logic [N-1:0]    r_breached, n_breached;
    logic [N-1:0]    r_over, n_over;
    logic [N-1:0]    r_fresh, n_fresh;
    logic [CW-1:0]   r_idx, n_idx;
    logic            r_pend, n_pend;
    logic [SW-1:0]   r_pidx, n_pidx;

    logic            wr_en_dl, wr_en_lf;
    logic [SW-1:0]   wr_addr;
    logic            rd_en;
    logic [SW-1:0]   rd_addr;
    logic [TW-1:0]   dl_q, lf_q;
    logic [TW-1:0]   age;
    logic            slot_late;
    logic            free_found;
    logic [SW-1:0]   free_slot;
    logic [SW-1:0]   line_slot;
    logic            line_ok;

    wdg_ram #(.DEPTH(N), .WIDTH(TW), .AW(SW)) u_deadline_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en_dl),
        .i_waddr (wr_addr),
        .i_wdata (r_req.limit_ms),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (dl_q)
    );

    wdg_ram #(.DEPTH(N), .WIDTH(TW), .AW(SW)) u_last_fed_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en_lf),
        .i_waddr (wr_addr),
        .i_wdata (r_req.now_ms),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (lf_q)
    );

    // lowest unarmed slot
    always_comb begin
        free_found = 1'b0;
        free_slot  = '0;
        for (int s = N - 1; s >= 0; s--) begin
            if (!r_armed[s]) begin
                free_found = 1'b1;
                free_slot  = SW'(s);
            end
        end
    end

    assign line_slot = SW'(r_req.line_id);
    assign line_ok   = (32'(r_req.line_id) < N) && r_armed[line_slot];

    // wrap-safe age of the slot whose memory data is back this cycle
    assign age       = r_req.now_ms - lf_q;
    assign slot_late = r_armed[r_pidx] && (age > dl_q);

    assign o_req_ready = (r_state == wdg_pkg::ST_IDLE);
    assign o_res_valid = (r_state == wdg_pkg::ST_DONE);
    assign o_res       = r_res;

    always_comb begin
        n_state    = r_state;
        n_res      = r_res;
        n_armed    = r_armed;
        n_breached = r_breached;
        n_over     = r_over;
        n_fresh    = r_fresh;
        n_idx      = r_idx;
        n_pend     = 1'b0;
        n_pidx     = r_pidx;
        wr_en_dl   = 1'b0;
        wr_en_lf   = 1'b0;
        wr_addr    = free_slot;
        rd_en      = 1'b0;
        rd_addr    = r_idx[SW-1:0];

        case (r_state)
            wdg_pkg::ST_IDLE: begin
                if (i_req_valid) begin
                    n_state = wdg_pkg::ST_EXEC;
                end
            end
            wdg_pkg::ST_EXEC: begin
                n_res   = '0;
                n_state = wdg_pkg::ST_DONE;
                case (r_req.kind)
                    wdg_pkg::KIND_REGISTER: begin
                        if (free_found) begin
                            wr_en_dl              = 1'b1;
                            wr_en_lf              = 1'b1;
                            wr_addr               = free_slot;
                            n_armed[free_slot]    = 1'b1;
                            n_breached[free_slot] = 1'b0;
                            n_res.ok              = 1'b1;
                            n_res.assigned_id     = wdg_pkg::LINE_W'(free_slot);
                        end
                    end
                    wdg_pkg::KIND_FEED: begin
                        if (line_ok) begin
                            wr_en_lf              = 1'b1;
                            wr_addr               = line_slot;
                            n_breached[line_slot] = 1'b0;
                            n_res.ok              = 1'b1;
                        end
                    end
                    wdg_pkg::KIND_CHECK: begin
                        n_state = wdg_pkg::ST_SCAN;
                        n_idx   = '0;
                        n_over  = '0;
                        n_fresh = '0;
                    end
                    wdg_pkg::KIND_CLEAR: begin
                        n_armed    = '0;
                        n_breached = '0;
                    end
                    default: begin
                        n_armed = r_armed;
                    end
                endcase
            end
            wdg_pkg::ST_SCAN: begin
                // issue one read per cycle, evaluate the slot read last cycle
                if (r_idx < CW'(N)) begin
                    rd_en  = 1'b1;
                    n_pend = 1'b1;
                    n_pidx = r_idx[SW-1:0];
                    n_idx  = r_idx + 1'b1;
                end
                if (r_pend && slot_late) begin
                    n_over[r_pidx] = 1'b1;
                    if (!r_breached[r_pidx]) begin
                        n_breached[r_pidx] = 1'b1;
                        n_fresh[r_pidx]    = 1'b1;
                    end
                end
                if (!(r_idx < CW'(N)) && !r_pend) begin
                    n_res                 = '0;
                    n_res.overdue_mask    = wdg_pkg::MASK_W'(r_over);
                    n_res.new_breach_mask = wdg_pkg::MASK_W'(r_fresh);
                    n_state               = wdg_pkg::ST_DONE;
                end
            end
            wdg_pkg::ST_DONE: begin
                if (i_res_take) begin
                    n_state = wdg_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = wdg_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= wdg_pkg::ST_IDLE;
            r_armed    <= '0;
            r_breached <= '0;
            r_pend     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_armed    <= n_armed;
            r_breached <= n_breached;
            r_pend     <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == wdg_pkg::ST_IDLE && i_req_valid) begin
            r_req <= i_req;
        end
        r_res   <= n_res;
        r_over  <= n_over;
        r_fresh <= n_fresh;
        r_idx   <= n_idx;
        r_pidx  <= n_pidx;
    end

endmodule

[sv/multi_channel_deadline_watchdog.sv]
// Watchdog over NUM_SLOTS channels: register, feed, check and clear requests,
// one result per request. A request is taken only when the block is idle;
// register, feed and clear pass through the execute state to the done state,
// and a check also walks the slots in a scan state before the done state,
// since deadlines and last-fed times sit in two slot memories with one read
// port each and the check walks them one slot per cycle. The result is held
// in an output register, so the next request is taken as soon as the result
// has moved there, even while the sink stalls.
module multi_channel_deadline_watchdog (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,  // line_id[2:0], limit_ms[34:3], now_ms[66:35]
    input  logic [1:0]  s_axis_tuser,  // kind[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata   // ok[0], assigned_id[3:1], overdue_mask[11:4],
                                       // new_breach_mask[19:12]
);

    wdg_pkg::t_req req;
    wdg_pkg::t_res res;
    logic          res_valid;
    logic          res_take;
    logic          r_out_valid;
    wdg_pkg::t_res r_out;

    assign req.kind     = wdg_pkg::t_kind'(s_axis_tuser);
    assign req.line_id  = s_axis_tdata[2:0];
    assign req.limit_ms = s_axis_tdata[34:3];
    assign req.now_ms   = s_axis_tdata[66:35];

    wdg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .o_req_ready (s_axis_tready),
        .i_req       (req),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_take  (res_take)
    );

    // output register takes a result when empty or being drained
    assign res_take = res_valid && (!r_out_valid || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0, r_out};

endmodule
